// ----- sv/lcdnw_pkg.sv -----
// Shared types, codes and constants for the character LCD nibble write sequencer.
package lcdnw_pkg;

    // Request action codes
    localparam logic [1:0] ACT_CMD   = 2'd0;
    localparam logic [1:0] ACT_CHAR  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_INIT  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PULSE  = 2'd0;
    localparam logic [1:0] CFG_SETTLE = 2'd1;
    localparam logic [1:0] CFG_WDELAY = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int HOLD_W     = 17;

    // Register reset values
    localparam logic [7:0]  PULSE_RST  = 8'd2;
    localparam logic [9:0]  SETTLE_RST = 10'd50;
    localparam logic [15:0] WDELAY_RST = 16'd2000;

    // Fixed delays
    localparam logic [HOLD_W-1:0] POWERUP_US     = 17'd50000;
    localparam logic [HOLD_W-1:0] CLEAR_EXTRA_US = 17'd3000;

    // Power-up command list
    localparam int INIT_LEN   = 6;
    localparam int INIT_IDX_W = $clog2(INIT_LEN);
    localparam logic [INIT_IDX_W-1:0] INIT_LAST_IDX = INIT_IDX_W'(INIT_LEN - 1);
    localparam logic [7:0] CLEAR_BYTE = 8'h01;

    function automatic logic [7:0] init_byte(input logic [INIT_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0C;
            3'd4:    b = 8'h06;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

    // Controller to datapath
    typedef struct packed {
        logic                  load;   // capture request beat
        logic                  emit;   // load one event into output register
        logic                  pwr;    // event is the all-low power-up wait
        logic [1:0]            phase;  // 0 hi/en, 1 hi/settle, 2 lo/en, 3 lo/settle
        logic [INIT_IDX_W-1:0] idx;    // byte number within init run
        logic                  last;   // final event of the run
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take an event this cycle
        logic is_init;   // captured request is the init action
    } t_stat;

endpackage

// ----- sv/lcdnw_if.sv -----
// Handshake channel interfaces for request and pin-event beats.
interface lcdnw_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface lcdnw_evt_if;
    logic                          valid;
    logic                          ready;
    logic                          reg_select;
    logic [3:0]                    nibble;
    logic                          enable;
    logic [lcdnw_pkg::HOLD_W-1:0]  hold_us;
    logic                          last;

    modport source (output valid, output reg_select, output nibble, output enable,
                    output hold_us, output last, input ready);
    modport sink   (input valid, input reg_select, input nibble, input enable,
                    input hold_us, input last, output ready);
endinterface

// ----- sv/char_lcd_nibble_write_sequencer.sv -----
// Top level: 4-bit character LCD write sequencer, controller plus datapath.
// One request is taken at a time and turned into a run of pin-event beats:
// a command, character or clear gives 4 beats, init gives 25 (a 50 ms
// all-low wait, then six command bytes). The controller emits one beat per
// clock while the output register drains; the next request is taken once
// the last beat of the run is in the output register. Timing registers
// are written through the cfg port: 0 pulse width, 1 settle, 2 write delay.
module char_lcd_nibble_write_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [lcdnw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lcdnw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lcdnw_req_if.sink                        i_req,
    lcdnw_evt_if.source                      o_evt
);

    lcdnw_pkg::t_cmd  w_cmd;
    lcdnw_pkg::t_stat w_stat;

    lcdnw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    lcdnw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_req.action),
        .i_data_byte  (i_req.data_byte),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_evt_ready  (o_evt.ready),
        .o_evt_valid  (o_evt.valid),
        .o_reg_select (o_evt.reg_select),
        .o_nibble     (o_evt.nibble),
        .o_enable     (o_evt.enable),
        .o_hold_us    (o_evt.hold_us),
        .o_last       (o_evt.last)
    );

endmodule

// ----- sv/lcdnw_ctrl.sv -----
// Sequencing state machine: walks power-up wait, bytes and nibble phases.
module lcdnw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  lcdnw_pkg::t_stat i_stat,
    output lcdnw_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_PWR  = 2'd2;
    localparam logic [1:0] S_RUN  = 2'd3;

    logic [1:0]                       r_state, n_state;
    logic [1:0]                       r_phase, n_phase;
    logic [lcdnw_pkg::INIT_IDX_W-1:0] r_idx,   n_idx;
    logic                             w_last;

    assign o_req_ready = (r_state == S_IDLE);

    // Last event: low-nibble settle of the final byte
    assign w_last = (r_phase == 2'd3) &&
                    (!i_stat.is_init || (r_idx == lcdnw_pkg::INIT_LAST_IDX));

    // Next state and command
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_idx     = r_idx;
        o_cmd     = '0;
        o_cmd.phase = r_phase;
        o_cmd.idx   = r_idx;
        o_cmd.last  = w_last;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_phase    = 2'd0;
                    n_idx      = '0;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = i_stat.is_init ? S_PWR : S_RUN;
            end
            S_PWR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.pwr  = 1'b1;
                    o_cmd.last = 1'b0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_phase    = r_phase + 2'd1;
                    if (r_phase == 2'd3) begin
                        n_idx = r_idx + lcdnw_pkg::INIT_IDX_W'(1);
                    end
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 2'd0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

endmodule

// ----- sv/lcdnw_dp.sv -----
// Datapath: timing registers, request capture, event forming and output register.
module lcdnw_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [lcdnw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lcdnw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [1:0]                         i_action,
    input  logic [7:0]                         i_data_byte,
    input  lcdnw_pkg::t_cmd                    i_cmd,
    output lcdnw_pkg::t_stat                   o_stat,
    input  logic                               i_evt_ready,
    output logic                               o_evt_valid,
    output logic                               o_reg_select,
    output logic [3:0]                         o_nibble,
    output logic                               o_enable,
    output logic [lcdnw_pkg::HOLD_W-1:0]       o_hold_us,
    output logic                               o_last
);

    logic [7:0]  r_pulse;
    logic [9:0]  r_settle;
    logic [15:0] r_wdelay;
    logic [1:0]  r_action;
    logic [7:0]  r_data;

    logic        r_valid;
    logic        r_rs;
    logic [3:0]  r_nib;
    logic        r_en;
    logic [lcdnw_pkg::HOLD_W-1:0] r_hold;
    logic        r_last;

    logic [7:0]  w_byte;
    logic [3:0]  w_nib;
    logic [lcdnw_pkg::HOLD_W-1:0] w_hold;
    logic [lcdnw_pkg::HOLD_W-1:0] w_extra;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse  <= lcdnw_pkg::PULSE_RST;
            r_settle <= lcdnw_pkg::SETTLE_RST;
            r_wdelay <= lcdnw_pkg::WDELAY_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                lcdnw_pkg::CFG_PULSE:  r_pulse  <= i_cfg_data[7:0];
                lcdnw_pkg::CFG_SETTLE: r_settle <= i_cfg_data[9:0];
                lcdnw_pkg::CFG_WDELAY: r_wdelay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_data   <= i_data_byte;
        end
    end

    assign o_stat.is_init  = (r_action == lcdnw_pkg::ACT_INIT);
    assign o_stat.out_free = !r_valid || i_evt_ready;

    // Byte on the bus for this event
    always_comb begin
        case (r_action)
            lcdnw_pkg::ACT_CMD,
            lcdnw_pkg::ACT_CHAR:  w_byte = r_data;
            lcdnw_pkg::ACT_CLEAR: w_byte = lcdnw_pkg::CLEAR_BYTE;
            default:              w_byte = lcdnw_pkg::init_byte(i_cmd.idx);
        endcase
    end

    assign w_nib = i_cmd.phase[1] ? w_byte[3:0] : w_byte[7:4];

    // Hold time: pulse, settle, or settle plus byte delay (plus clear wait at run end)
    assign w_extra = (i_cmd.last &&
                      (r_action inside {lcdnw_pkg::ACT_CLEAR, lcdnw_pkg::ACT_INIT}))
                     ? lcdnw_pkg::CLEAR_EXTRA_US : '0;

    always_comb begin
        case (i_cmd.phase)
            2'd1:    w_hold = 17'(r_settle);
            2'd3:    w_hold = 17'(r_settle) + 17'(r_wdelay) + w_extra;
            default: w_hold = 17'(r_pulse);
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_evt_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (i_cmd.pwr) begin
                r_rs   <= 1'b0;
                r_nib  <= 4'd0;
                r_en   <= 1'b0;
                r_hold <= lcdnw_pkg::POWERUP_US;
                r_last <= 1'b0;
            end else begin
                r_rs   <= (r_action == lcdnw_pkg::ACT_CHAR);
                r_nib  <= w_nib;
                r_en   <= !i_cmd.phase[0];
                r_hold <= w_hold;
                r_last <= i_cmd.last;
            end
        end
    end

    assign o_evt_valid  = r_valid;
    assign o_reg_select = r_rs;
    assign o_nibble     = r_nib;
    assign o_enable     = r_en;
    assign o_hold_us    = r_hold;
    assign o_last       = r_last;

endmodule

// ----- sv/lcdnw_chk.sv -----
// Port-level checker for the LCD write sequencer, bound to the top level.
module lcdnw_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic                            i_evt_valid,
    input logic                            i_evt_ready,
    input logic                            i_evt_enable,
    input logic                            i_evt_last,
    input logic [lcdnw_pkg::HOLD_W-1:0]    i_evt_hold_us
);

    // One request at a time: ready drops right after a request beat
    a_req_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while a run is starting");

    // An enable-high beat is never the end of a run
    a_en_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt_valid && i_evt_enable) |-> !i_evt_last)
        else $error("run ended with enable high");

    // Before the last beat of a run goes out, no new request is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt_valid && !i_evt_last) |-> !i_req_ready)
        else $error("request ready in the middle of a run");

    // A stalled beat holds its hold time
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt_valid && !i_evt_ready) |=> (i_evt_valid && $stable(i_evt_hold_us)))
        else $error("stalled beat changed");

endmodule

bind char_lcd_nibble_write_sequencer lcdnw_chk u_lcdnw_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_evt_valid   (o_evt.valid),
    .i_evt_ready   (o_evt.ready),
    .i_evt_enable  (o_evt.enable),
    .i_evt_last    (o_evt.last),
    .i_evt_hold_us (o_evt.hold_us)
);
